// ----- sv/cpr_pkg.sv -----
// Shared types and constants for the cycle perturbation ratio core.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package cpr_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_ITEMS_DEF   = 65536;
  localparam int VALUE_BITS_DEF  = 24;

  // Fixed field widths
  localparam int RATIO_W         = 18;   // Q2.16
  localparam int FRAC_W          = 16;
  localparam int TERMS_W         = 17;
  localparam int STATUS_W        = 2;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 24;
  localparam int MIN_VALID_RESET = 16;

  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID = 1'b1;

  // Mode codes
  localparam logic MODE_LOCAL = 1'b0;
  localparam logic MODE_THREE = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_TOO_FEW  = 2'd1,
    ST_NO_TERMS = 2'd2,
    ST_TOO_LONG = 2'd3
  } cpr_status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic acc;     // accumulate the input word
    logic setup;   // grade the sequence, load divider, clear sequence state
    logic check;   // early-out check (bad status or saturation)
    logic step;    // one quotient bit
    logic load;    // move result into the output register
  } cpr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic early;     // no iteration needed
    logic out_busy;  // output register holds a word that is stalled
  } cpr_sts_t;

endpackage

`default_nettype wire

// ----- sv/cpr_datapath.sv -----
// Datapath: config registers, sequence accumulators, restoring divider, output register.
// Depends on cpr_pkg; driven by cpr_controller through cpr_cmd_t.
`default_nettype none

module cpr_datapath #(
  parameter int MAX_ITEMS  = 65536,
  parameter int VALUE_BITS = 24
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_valid,
  input  wire  [cpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [cpr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire  [VALUE_BITS-1:0]            value,
  input  wire                              out_stall,
  input  cpr_pkg::cpr_cmd_t                cmd,
  output cpr_pkg::cpr_sts_t                sts,
  output logic                             out_valid,
  output logic [cpr_pkg::RATIO_W-1:0]      ratio,
  output logic [cpr_pkg::TERMS_W-1:0]      valid_terms,
  output logic [cpr_pkg::STATUS_W-1:0]     status
);
  import cpr_pkg::*;

  localparam int CNT_W  = $clog2(MAX_ITEMS + 2);
  localparam int LOG_W  = $clog2(MAX_ITEMS);
  localparam int VSUM_W = VALUE_BITS + LOG_W;
  localparam int DSUM_W = VALUE_BITS + 1 + LOG_W;
  localparam int DEN_W  = VSUM_W + 2;
  localparam int REM_W  = DEN_W + 1;
  localparam int DEV_W  = VALUE_BITS + 2;
  localparam int CMP_W  = (VALUE_BITS > CFG_DATA_W) ? VALUE_BITS : CFG_DATA_W;

  // Config
  logic                  mode;
  logic [CFG_DATA_W-1:0] min_valid;

  // Sequence state
  logic [VALUE_BITS-1:0] prev_value;
  logic [VALUE_BITS-1:0] prev_prev_value;
  logic [DSUM_W-1:0]     deviation_sum;
  logic [VSUM_W-1:0]     value_sum;
  logic [CNT_W-1:0]      term_count;
  logic [CNT_W-1:0]      item_count;

  // Divider
  logic [DEN_W-1:0]      den;
  logic [REM_W-1:0]      rem;
  logic [RATIO_W-1:0]    sh;
  logic [RATIO_W-1:0]    quo;
  cpr_status_t           res_status;
  logic [TERMS_W-1:0]    res_terms;

  // Per-word terms
  logic [CMP_W-1:0]  v_c, p_c, pp_c, mv_c;
  logic              active, seen_one, seen_two;
  logic              use_local, use_three, use_term;
  logic [DEV_W-1:0]  twice, outer, dev_three, dev_local, dev_add;
  logic [VALUE_BITS-1:0] val_add;

  always_comb begin
    v_c  = CMP_W'(value);
    p_c  = CMP_W'(prev_value);
    pp_c = CMP_W'(prev_prev_value);
    mv_c = CMP_W'(min_valid);
    active   = item_count < CNT_W'(MAX_ITEMS);
    seen_one = item_count != '0;
    seen_two = item_count >= CNT_W'(2);
    use_local = seen_one && (v_c > mv_c) && (p_c > mv_c);
    use_three = seen_two && (v_c >= mv_c) && (p_c >= mv_c) && (pp_c >= mv_c);
    twice = {1'b0, prev_value, 1'b0};
    outer = DEV_W'(prev_prev_value) + DEV_W'(value);
    dev_three = (twice > outer) ? (twice - outer) : (outer - twice);
    dev_local = (value > prev_value) ? DEV_W'(value - prev_value)
                                     : DEV_W'(prev_value - value);
    if (mode == MODE_LOCAL) begin
      use_term = active && use_local;
      dev_add  = dev_local;
      val_add  = value;
    end else begin
      use_term = active && use_three;
      dev_add  = dev_three;
      val_add  = prev_value;
    end
  end

  // Sequence grading at setup (registers already hold the final word)
  cpr_status_t       grade;
  logic [CNT_W-1:0]  need;
  logic [DEN_W-1:0]  den_setup;

  always_comb begin
    need = (mode == MODE_LOCAL) ? CNT_W'(2) : CNT_W'(3);
    if (item_count > CNT_W'(MAX_ITEMS)) begin
      grade = ST_TOO_LONG;
    end else if (item_count < need) begin
      grade = ST_TOO_FEW;
    end else if (term_count == '0 || value_sum == '0) begin
      grade = ST_NO_TERMS;
    end else begin
      grade = ST_OK;
    end
    if (mode == MODE_LOCAL) begin
      den_setup = DEN_W'(value_sum);
    end else begin
      den_setup = DEN_W'(value_sum) + {1'b0, value_sum, 1'b0};
    end
  end

  // Divider step: shift in next dividend bit, subtract when it fits
  logic [REM_W-1:0] rem_sh;
  logic             fits;
  logic             sat;

  always_comb begin
    rem_sh = {rem[REM_W-2:0], sh[RATIO_W-1]};
    fits   = rem_sh >= REM_W'(den);
    sat    = rem >= REM_W'(den);
    sts.early    = (res_status != ST_OK) || sat;
    sts.out_busy = out_valid && out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_LOCAL;
      min_valid       <= CFG_DATA_W'(MIN_VALID_RESET);
      prev_value      <= '0;
      prev_prev_value <= '0;
      deviation_sum   <= '0;
      value_sum       <= '0;
      term_count      <= '0;
      item_count      <= '0;
      out_valid       <= 1'b0;
    end else begin
      // config writes
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MODE:      mode      <= cfg_data[0];
          REG_MIN_VALID: min_valid <= cfg_data;
        endcase
      end

      // accumulate one word
      if (cmd.acc) begin
        if (item_count <= CNT_W'(MAX_ITEMS)) begin
          item_count <= item_count + 1'b1;
        end
        if (active) begin
          prev_prev_value <= prev_value;
          prev_value      <= value;
          if (use_term) begin
            deviation_sum <= deviation_sum + DSUM_W'(dev_add);
            value_sum     <= value_sum + VSUM_W'(val_add);
            term_count    <= term_count + 1'b1;
          end
        end
      end

      // close the sequence
      if (cmd.setup) begin
        prev_value      <= '0;
        prev_prev_value <= '0;
        deviation_sum   <= '0;
        value_sum       <= '0;
        term_count      <= '0;
        item_count      <= '0;
      end

      // output register
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Divider and result payload
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      den        <= den_setup;
      rem        <= REM_W'(deviation_sum >> 2);
      sh         <= {deviation_sum[1:0], {FRAC_W{1'b0}}};
      res_status <= grade;
      res_terms  <= TERMS_W'(term_count);
    end
    if (cmd.check) begin
      quo <= (res_status == ST_OK && sat) ? RATIO_MAX : '0;
    end
    if (cmd.step) begin
      rem <= fits ? (rem_sh - REM_W'(den)) : rem_sh;
      quo <= {quo[RATIO_W-2:0], fits};
      sh  <= {sh[RATIO_W-2:0], 1'b0};
    end
    if (cmd.load) begin
      ratio       <= quo;
      valid_terms <= res_terms;
      status      <= res_status;
    end
  end

  // Checks
  a_ratio_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> ratio == '0)
    else $error("nonzero ratio with error status");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> rem < REM_W'(den))
    else $error("divider remainder out of range");

  a_item_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_count <= CNT_W'(MAX_ITEMS + 1))
    else $error("item count past saturation");

endmodule

`default_nettype wire

// ----- sv/cpr_controller.sv -----
// Controller: sequences accumulation, divider setup, iterations and result load.
// Depends on cpr_pkg; drives cpr_datapath through cpr_cmd_t.
`default_nettype none

module cpr_controller (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  input  wire                in_last,
  output logic               in_stall,
  input  cpr_pkg::cpr_sts_t  sts,
  output cpr_pkg::cpr_cmd_t  cmd
);
  import cpr_pkg::*;

  localparam int ITER_W = $clog2(RATIO_W);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(RATIO_W - 1);

  typedef enum logic [2:0] {
    S_ACC,
    S_SETUP,
    S_CHECK,
    S_RUN,
    S_LOAD
  } state_t;

  state_t            state;
  logic [ITER_W-1:0] iter;

  // State and iteration count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      iter  <= '0;
    end else begin
      unique case (state)
        S_ACC: begin
          if (in_valid && in_last) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          iter  <= '0;
          state <= sts.early ? S_LOAD : S_RUN;
        end
        S_RUN: begin
          if (iter == ITER_LAST) begin
            state <= S_LOAD;
          end else begin
            iter <= iter + 1'b1;
          end
        end
        S_LOAD: begin
          if (!sts.out_busy) begin
            state <= S_ACC;
          end
        end
        default: state <= S_ACC;
      endcase
    end
  end

  // Commands
  always_comb begin
    in_stall  = (state != S_ACC);
    cmd       = '0;
    cmd.acc   = (state == S_ACC) && in_valid;
    cmd.setup = (state == S_SETUP);
    cmd.check = (state == S_CHECK);
    cmd.step  = (state == S_RUN);
    cmd.load  = (state == S_LOAD) && !sts.out_busy;
  end

  // Checks
  a_last_starts_setup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_last) |=> cmd.setup)
    else $error("last word did not start divider setup");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !sts.out_busy)
    else $error("result loaded over a stalled word");

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> iter <= ITER_LAST)
    else $error("divider iteration count overrun");

endmodule

`default_nettype wire

// ----- sv/cycle_perturbation_ratio_core.sv -----
// Top level of the cycle perturbation ratio core (jitter/shimmer, local and RAP/APQ3).
// Depends on cpr_pkg, cpr_controller and cpr_datapath.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   in      | in_valid / in_stall    | value, last
//   out     | out_valid / out_stall  | ratio, valid_terms, status
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One value word is taken per cycle while a sequence accumulates.
// A word marked last stalls the input through setup, check, the restoring
// divider (one quotient bit per cycle) and result load; the divider is skipped
// on an error status or a saturated ratio, and the load waits on a stalled output word.
// The next sequence can start while the previous result waits on out_stall.
// Reset is synchronous, active high; it clears all sequence state and sets config to its defaults.
`default_nettype none

module cycle_perturbation_ratio_core #(
  parameter int MAX_ITEMS  = cpr_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = cpr_pkg::VALUE_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [VALUE_BITS-1:0]            value,
  input  wire                              last,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [cpr_pkg::RATIO_W-1:0]      ratio,
  output logic [cpr_pkg::TERMS_W-1:0]      valid_terms,
  output logic [cpr_pkg::STATUS_W-1:0]     status,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [cpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [cpr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cpr_pkg::*;

  cpr_cmd_t cmd;
  cpr_sts_t sts;

  // Config registers take a write on any cycle
  assign cfg_ready = 1'b1;

  cpr_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cpr_datapath #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .value       (value),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .ratio       (ratio),
    .valid_terms (valid_terms),
    .status      (status)
  );

endmodule

`default_nettype wire
